// File: rtl/core/gfm_pkg.sv
// shared constants and helpers for the GF(2^n) multiplier
// no dependencies
`default_nettype none

package gfm_pkg;

    // fixed port widths
    localparam int FIELD_W   = 63;
    localparam int DEGREE_W  = 6;
    localparam int CFG_IDX_W = 2;

    // shift-and-add steps folded into one pipeline stage
    localparam int STAGE_STEPS = 4;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCTION    = 2'd1;

    // reset configuration: GF(2^8), x^8+x^4+x^3+x+1
    localparam logic [DEGREE_W-1:0] RESET_DEGREE    = 6'd8;
    localparam logic [FIELD_W-1:0]  RESET_REDUCTION = 63'd27;

    // cycles from an accepted start to the done strobe
    function automatic int pipe_latency(input int max_degree);
        return 1 + (max_degree + STAGE_STEPS - 1) / STAGE_STEPS;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/gfm_stage.sv
// one pipeline stage of the multiplier: STAGE_STEPS shift-and-add steps
// with conditional reduction; uses gfm_pkg
`default_nettype none

module gfm_stage #(
    parameter int DATA_W = 63
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DATA_W-1:0] mask,
    input  wire logic [DATA_W-1:0] top_bit,
    input  wire logic [DATA_W-1:0] poly,
    input  wire logic              in_valid,
    input  wire logic [DATA_W-1:0] in_a,
    input  wire logic [DATA_W-1:0] in_mult,
    input  wire logic [DATA_W-1:0] in_acc,
    output logic                   out_valid,
    output logic      [DATA_W-1:0] out_a,
    output logic      [DATA_W-1:0] out_mult,
    output logic      [DATA_W-1:0] out_acc
);

    logic              valid_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] mult_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] a_next;
    logic [DATA_W-1:0] mult_next;
    logic [DATA_W-1:0] acc_next;

    always_comb
    begin
        logic carry;
        a_next    = in_a;
        mult_next = in_mult;
        acc_next  = in_acc;
        for (int s = 0; s < gfm_pkg::STAGE_STEPS; s++)
        begin
            if (a_next[0])
            begin
                acc_next = acc_next ^ mult_next;
            end
            carry     = |(mult_next & top_bit);
            mult_next = (mult_next << 1) & mask;
            if (carry)
            begin
                mult_next = mult_next ^ poly;
            end
            a_next = a_next >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload carries no reset
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        mult_reg <= mult_next;
        acc_reg  <= acc_next;
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_mult  = mult_reg;
    assign out_acc   = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/gf2n_multiplier.sv
// top level of the GF(2^n) polynomial-basis multiplier
// depends on gfm_pkg and gfm_stage
`default_nettype none

// usage
//   command channel: present operand_a and operand_b with start high; the
//   word is taken at any edge where start is high and busy is low. busy
//   is always low, so one multiplication can enter every cycle.
//   result channel: product sits on the ports with done high for exactly
//   one cycle, once the word has passed the input register and every
//   stage. the receiver cannot hold results off and there is no stall
//   path; words come out in order. the pipeline is the shift-and-add
//   chain: one input register that masks the operands, then one stage
//   per four bits of operand_a, each doing four shift / reduce steps.
//   configuration channel: cfg_index 0 writes the field degree (clamped
//   to MAX_DEGREE), index 1 writes the low bits of the modulus; other
//   indexes are dropped. cfg_ready is always high. write only while no
//   multiplication is in flight; all stages read the same settings.
//   reset: all valid bits clear, so no done strobe until new words enter;
//   configuration returns to GF(2^8) with modulus x^8+x^4+x^3+x+1.
//   bits of product above the field degree are always zero.

module gf2n_multiplier #(
    parameter int MAX_DEGREE = 63
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [gfm_pkg::FIELD_W-1:0]    operand_a,
    input  wire logic [gfm_pkg::FIELD_W-1:0]    operand_b,
    output logic                                done,
    output logic      [gfm_pkg::FIELD_W-1:0]    product,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gfm_pkg::FIELD_W-1:0]    cfg_data
);

    localparam int DATA_W     = MAX_DEGREE;
    localparam int DEG_W      = gfm_pkg::DEGREE_W;
    localparam int NUM_STAGES = (MAX_DEGREE + gfm_pkg::STAGE_STEPS - 1) / gfm_pkg::STAGE_STEPS;
    localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ONE  = DATA_W'(1);
    // reset degree, clamped like any written degree
    localparam int RESET_N = (int'(gfm_pkg::RESET_DEGREE) > MAX_DEGREE) ?
                             MAX_DEGREE : int'(gfm_pkg::RESET_DEGREE);

    // derived configuration, held in mask form so every stage uses it directly
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] poly_reg, poly_next;
    logic [DATA_W-1:0] poly_used;
    logic [DEG_W-1:0]  deg_sat;
    logic              cfg_write;

    // pipeline chain: entry 0 is the input register
    logic              valid_pipe [NUM_STAGES+1];
    logic [DATA_W-1:0] a_pipe     [NUM_STAGES+1];
    logic [DATA_W-1:0] mult_pipe  [NUM_STAGES+1];
    logic [DATA_W-1:0] acc_pipe   [NUM_STAGES+1];

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_a_reg;
    logic [DATA_W-1:0] in_b_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // clamp degree, then build the operand mask and the x^(n-1) probe; also takes modulus writes
    always_comb
    begin
        if (cfg_data[DEG_W-1:0] > DEG_W'(MAX_DEGREE))
        begin
            deg_sat = DEG_W'(MAX_DEGREE);
        end
        else
        begin
            deg_sat = cfg_data[DEG_W-1:0];
        end

        mask_next = mask_reg;
        top_next  = top_reg;
        poly_next = poly_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                gfm_pkg::REG_FIELD_DEGREE:
                begin
                    if (deg_sat == '0)
                    begin
                        mask_next = '0;
                        top_next  = '0;
                    end
                    else
                    begin
                        mask_next = ONES >> (DEG_W'(DATA_W) - deg_sat);
                        top_next  = ONE << (deg_sat - DEG_W'(1));
                    end
                end
                gfm_pkg::REG_REDUCTION:
                begin
                    poly_next = cfg_data[DATA_W-1:0];
                end
                default:
                begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= ONES >> (DATA_W - RESET_N);
            top_reg      <= ONE << (RESET_N - 1);
            poly_reg     <= gfm_pkg::RESET_REDUCTION[DATA_W-1:0];
            in_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg     <= mask_next;
            top_reg      <= top_next;
            poly_reg     <= poly_next;
            in_valid_reg <= start && !busy;
        end
    end

    // operand capture, masked to the field
    always_ff @(posedge clk)
    begin
        in_a_reg <= operand_a[DATA_W-1:0] & mask_reg;
        in_b_reg <= operand_b[DATA_W-1:0] & mask_reg;
    end

    assign poly_used = poly_reg & mask_reg;

    assign valid_pipe[0] = in_valid_reg;
    assign a_pipe[0]     = in_a_reg;
    assign mult_pipe[0]  = in_b_reg;
    assign acc_pipe[0]   = '0;

    // each stage eats four bits of operand_a, low bit first
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        gfm_stage #(
            .DATA_W (DATA_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .mask      (mask_reg),
            .top_bit   (top_reg),
            .poly      (poly_used),
            .in_valid  (valid_pipe[g]),
            .in_a      (a_pipe[g]),
            .in_mult   (mult_pipe[g]),
            .in_acc    (acc_pipe[g]),
            .out_valid (valid_pipe[g+1]),
            .out_a     (a_pipe[g+1]),
            .out_mult  (mult_pipe[g+1]),
            .out_acc   (acc_pipe[g+1])
        );
    end

    // result word, zero above the datapath width
    assign done    = valid_pipe[NUM_STAGES];
    assign product = gfm_pkg::FIELD_W'(acc_pipe[NUM_STAGES]);

endmodule

`default_nettype wire

// File: rtl/core/gfm_checker.sv
// port-level checks for gf2n_multiplier, bound to the top level
// depends on gfm_pkg
`default_nettype none

module gfm_checker #(
    parameter int MAX_DEGREE = 63
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [gfm_pkg::FIELD_W-1:0]   operand_a,
    input wire logic                          done,
    input wire logic [gfm_pkg::FIELD_W-1:0]   product
);

    localparam int LAT = gfm_pkg::pipe_latency(MAX_DEGREE);

    // every accepted word later yields a done strobe
    a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word produced no done strobe");

    // no done strobe without a word accepted at the matching edge
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("done strobe without matching accepted word");

    // zero first operand always multiplies to zero
    a_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operand_a == '0)) |-> ##LAT (product == '0))
        else $error("zero operand_a gave nonzero product");

endmodule

bind gf2n_multiplier gfm_checker #(
    .MAX_DEGREE (MAX_DEGREE)
) u_gfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operand_a (operand_a),
    .done      (done),
    .product   (product)
);

`default_nettype wire
